// ----- src/lef_pkg.sv -----
// Shared constants and types for the 2D label edge filter.
// No dependencies; used by the stream interfaces and the top level.
`timescale 1ns / 1ps

package lef_pkg;

  localparam int LABEL_BITS = 16;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // size registers are 11 bits wide
  localparam int SIZE_BITS = 11;
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT + 1);

  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 3;

  // register byte addresses
  localparam logic [ADDR_BITS-1:0] ADDR_FRAME_WIDTH  = 3'd0;
  localparam logic [ADDR_BITS-1:0] ADDR_FRAME_HEIGHT = 3'd4;

  localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 11'd1024;
  localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 11'd1024;

  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [SIZE_BITS-1:0]  size_t;

endpackage

// ----- src/lef_if.sv -----
// Stream channel interfaces for the label edge filter: pixel requests in, labels out.
// Depends on lef_pkg.
`timescale 1ns / 1ps

interface lef_in_if;
  logic            valid;
  logic            ready;
  logic            cmd;
  logic            start_of_frame;
  lef_pkg::label_t pixel_label;

  modport source (output valid, output cmd, output start_of_frame, output pixel_label,
                  input ready);
  modport sink   (input valid, input cmd, input start_of_frame, input pixel_label,
                  output ready);
endinterface

interface lef_out_if;
  logic            valid;
  logic            ready;
  lef_pkg::label_t out_label;
  logic            end_of_frame;

  modport source (output valid, output out_label, output end_of_frame, input ready);
  modport sink   (input valid, input out_label, input end_of_frame, output ready);
endinterface

// ----- src/label_edge_filter_2d_top.sv -----
// Latency: a pixel request yields its output one frame row later; the result register
// is loaded at the accepting edge and shown in the next cycle.
// Throughput: one request per cycle unless output is stalled; set by the registered
// line store reads, addressed from the next column so data is ready for the request.
// Reset (rst, synchronous): sizes return to 1024 x 1024, counters clear, no frame is
// active; line store contents stay undefined until written.
`timescale 1ns / 1ps

module label_edge_filter_2d_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lef_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [lef_pkg::DATA_BITS-1:0]   pwdata,
  output logic [lef_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  lef_in_if.sink                          in_stream,
  lef_out_if.source                       out_stream
);

  localparam int SB = lef_pkg::SIZE_BITS;
  localparam int CB = lef_pkg::COL_BITS;
  localparam int RB = lef_pkg::ROW_BITS;

  // configuration
  lef_pkg::size_t frame_width;
  lef_pkg::size_t frame_height;
  lef_pkg::size_t w;
  lef_pkg::size_t h;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lef_pkg::RESET_WIDTH;
      frame_height <= lef_pkg::RESET_HEIGHT;
    end else if (psel && penable && pwrite) begin
      if (paddr == lef_pkg::ADDR_FRAME_WIDTH) begin
        frame_width <= pwdata[SB-1:0];
      end else if (paddr == lef_pkg::ADDR_FRAME_HEIGHT) begin
        frame_height <= pwdata[SB-1:0];
      end
    end
  end

  always_comb begin
    case (paddr)
      lef_pkg::ADDR_FRAME_WIDTH:  prdata = {{(lef_pkg::DATA_BITS-SB){1'b0}}, frame_width};
      lef_pkg::ADDR_FRAME_HEIGHT: prdata = {{(lef_pkg::DATA_BITS-SB){1'b0}}, frame_height};
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    if (frame_width == '0) w = SB'(1);
    else if (frame_width > SB'(lef_pkg::MAX_WIDTH)) w = SB'(lef_pkg::MAX_WIDTH);
    else w = frame_width;
    if (frame_height == '0) h = SB'(1);
    else if (frame_height > SB'(lef_pkg::MAX_HEIGHT)) h = SB'(lef_pkg::MAX_HEIGHT);
    else h = frame_height;
  end

  // position state
  lef_pkg::col_t in_column, in_column_next;
  lef_pkg::row_t in_row, in_row_next;
  logic          frame_active, frame_active_next;

  // line stores and their registered read ports
  lef_pkg::label_t row_store_newer [lef_pkg::MAX_WIDTH];
  lef_pkg::label_t row_store_older [lef_pkg::MAX_WIDTH];
  lef_pkg::label_t rd_centre_raw, rd_right_raw, rd_up_raw;
  lef_pkg::label_t byp_newer_data, byp_older_data;
  logic            byp_centre, byp_right, byp_up;
  lef_pkg::col_t   raddr_centre, raddr_right;

  // copies of the first entries, for a frame start in mid stream
  lef_pkg::label_t first_newer0, first_newer1, first_older0;
  lef_pkg::label_t win_left;

  // output register
  logic            out_valid;
  lef_pkg::label_t out_label_q;
  logic            out_eof_q;

  logic            accept, sof, proc, emit, wrap, last, interior, store_we;
  lef_pkg::col_t   c_eff;
  lef_pkg::row_t   r_eff;
  logic            fa_eff;
  lef_pkg::size_t  c_plus1, c_plus2;
  lef_pkg::label_t centre, up, right_raw, pix, res;

  assign in_stream.ready = !out_valid || out_stream.ready;
  assign accept          = in_stream.valid && in_stream.ready;
  assign sof             = accept && !in_stream.cmd && in_stream.start_of_frame;
  assign pix             = in_stream.pixel_label;

  always_comb begin
    c_eff  = sof ? '0 : in_column;
    r_eff  = sof ? '0 : in_row;
    fa_eff = sof || frame_active;
    proc   = accept && fa_eff && (in_stream.cmd == (SB'(r_eff) >= h));

    centre    = sof ? first_newer0 : (byp_centre ? byp_newer_data : rd_centre_raw);
    right_raw = sof ? first_newer1 : (byp_right  ? byp_newer_data : rd_right_raw);
    up        = sof ? first_older0 : (byp_up     ? byp_older_data : rd_up_raw);

    c_plus1 = SB'(c_eff) + SB'(1);
    c_plus2 = SB'(c_eff) + SB'(2);
    emit    = r_eff >= RB'(1);
    wrap    = c_plus1 >= w;
    last    = emit && in_stream.cmd && wrap;

    // border rows and columns are copied
    interior = !in_stream.cmd && (r_eff >= RB'(2)) && (c_eff >= CB'(1)) && (c_plus2 <= w)
               && (centre != '0) && (up == centre) && (pix == centre)
               && (win_left == centre) && (right_raw == centre);
    res      = interior ? '0 : centre;
    store_we = proc && !in_stream.cmd;

    in_column_next    = in_column;
    in_row_next       = in_row;
    frame_active_next = frame_active;
    if (proc) begin
      in_column_next    = wrap ? '0 : c_plus1[CB-1:0];
      in_row_next       = (wrap && !last) ? r_eff + RB'(1) : r_eff;
      frame_active_next = !last;
    end

    // point the read ports at the column the next request will use
    raddr_centre = rst ? '0 : in_column_next;
    raddr_right  = raddr_centre + CB'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column    <= '0;
      in_row       <= '0;
      frame_active <= 1'b0;
    end else begin
      in_column    <= in_column_next;
      in_row       <= in_row_next;
      frame_active <= frame_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      row_store_newer[c_eff] <= pix;
      row_store_older[c_eff] <= centre;
    end
    rd_centre_raw  <= row_store_newer[raddr_centre];
    rd_right_raw   <= row_store_newer[raddr_right];
    rd_up_raw      <= row_store_older[raddr_centre];
    // forward a write that lands on an address being read
    byp_centre     <= store_we && (c_eff == raddr_centre);
    byp_right      <= store_we && (c_eff == raddr_right);
    byp_up         <= store_we && (c_eff == raddr_centre);
    byp_newer_data <= pix;
    byp_older_data <= centre;
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      win_left <= centre;
      if (c_eff == CB'(0)) begin
        first_newer0 <= pix;
        first_older0 <= centre;
      end
      if (c_eff == CB'(1)) begin
        first_newer1 <= pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && emit) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_label_q <= res;
      out_eof_q   <= last;
    end
  end

  assign out_stream.valid        = out_valid;
  assign out_stream.out_label    = out_label_q;
  assign out_stream.end_of_frame = out_eof_q;

endmodule
